[hdl/xxh64_pkg.sv]
// Shared types, XXH64 prime constants and the rotate helper.
// Used by the multiply unit and the top level; depends on nothing.
package xxh64_pkg;

  typedef logic [63:0] u64_t;

  localparam u64_t PRIME1     = 64'd11400714785074694791;
  localparam u64_t PRIME2     = 64'd14029467366897019727;
  localparam u64_t PRIME3     = 64'd1609587929392839161;
  localparam u64_t PRIME4     = 64'd9650029242287828579;
  localparam u64_t PRIME5     = 64'd2870177450012600261;
  localparam u64_t SEED_RESET = 64'h717174414E000042;

  // Rotate left by a constant amount between 1 and 63
  function automatic u64_t rotl64(u64_t v, int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

endpackage

[hdl/xxh64_mul.sv]
// Shared 64x64 multiplier (low 64 bits of the product) built on one
// 32x32 multiplier, summing three partial products. Depends on xxh64_pkg.
module xxh64_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  xxh64_pkg::u64_t  a_i,
  input  xxh64_pkg::u64_t  b_i,
  output logic             done_o,
  output xxh64_pkg::u64_t  result_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LL   = 2'd1;
  localparam logic [1:0] PH_LH   = 2'd2;
  localparam logic [1:0] PH_HL   = 2'd3;

  logic [1:0]      phase_q, phase_d;
  xxh64_pkg::u64_t a_q, b_q;
  xxh64_pkg::u64_t acc_q, acc_d;
  logic [31:0]     mul_x, mul_y;
  logic [63:0]     prod;

  // Select the partial product for this phase
  always_comb begin
    unique case (phase_q)
      PH_LH: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      PH_HL: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
      default: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
    endcase
  end

  assign prod = {32'd0, mul_x} * {32'd0, mul_y};

  // Accumulate partial products and advance the phase
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    unique case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_LL;
      PH_LL: begin
        acc_d   = prod;
        phase_d = PH_LH;
      end
      PH_LH: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        phase_d = PH_HL;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign done_o   = (phase_q == PH_HL);
  assign result_o = acc_q + {prod[31:0], 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Hold operands and running sum
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    acc_q <= acc_d;
  end

endmodule

[hdl/xxhash64_stream_hasher_top.sv]
// Streaming XXH64 hasher: sequencer, lane state and APB seed register.
// Depends on xxh64_pkg and xxh64_mul.
//
// Usage: send the message as 64-bit little-endian words on word_i with
// byte_count_i (1..8) and last_i, under in_valid_i/in_ready_o. Only the last
// word may be partial; a partial word always ends the message. The digest
// appears on digest_o under out_valid_o/out_ready_i, one per message.
// The user must write the seed over the APB port at address 0 only while the
// block is idle; the block itself does not enforce this. Every multiply goes
// through one shared 64x64 unit (one 32x32 multiplier, three partial
// products). A full word that only enters the pending buffer needs no
// multiply; a word closing a 32-byte stripe takes 8 multiplies. The finish
// takes 12 multiplies for the lanes when a stripe was seen, 3 per pending or
// full tail word, 2 for a 4-byte tail, 2 per remaining byte and 2 for the
// final avalanche.
// Reset clears the message state and loads the default seed. While a digest
// waits for out_ready_i, the next message is accepted and hashed; the block
// stalls only when a second digest is ready before the first is taken.
module xxhash64_stream_hasher_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LR1   = 5'd1;
  localparam logic [4:0] S_LR2   = 5'd2;
  localparam logic [4:0] S_FINIT = 5'd3;
  localparam logic [4:0] S_ML1   = 5'd4;
  localparam logic [4:0] S_ML2   = 5'd5;
  localparam logic [4:0] S_ML3   = 5'd6;
  localparam logic [4:0] S_LEN   = 5'd7;
  localparam logic [4:0] S_T1    = 5'd8;
  localparam logic [4:0] S_T2    = 5'd9;
  localparam logic [4:0] S_T3    = 5'd10;
  localparam logic [4:0] S_P4    = 5'd11;
  localparam logic [4:0] S_P4B   = 5'd12;
  localparam logic [4:0] S_B1    = 5'd13;
  localparam logic [4:0] S_B2    = 5'd14;
  localparam logic [4:0] S_AV1   = 5'd15;
  localparam logic [4:0] S_AV2   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0]       state_q, state_d;
  xxh64_pkg::u64_t  seed_q;
  xxh64_pkg::u64_t  lane_q [4];
  xxh64_pkg::u64_t  lane_d [4];
  xxh64_pkg::u64_t  pend_q [3];
  logic             pend_we;
  logic [1:0]       pcnt_q, pcnt_d;
  logic [LENGTH_BITS-1:0] total_q, total_d;
  logic             stripe_q, stripe_d;
  xxh64_pkg::u64_t  w_q, w_d;
  logic [3:0]       n_q, n_d;
  logic             end_q, end_d;
  xxh64_pkg::u64_t  h_q, h_d;
  xxh64_pkg::u64_t  t_q, t_d;
  logic [1:0]       i_q, i_d;
  logic [2:0]       b_q, b_d;
  logic             issued_q, issued_d;
  logic             out_valid_q, out_valid_d;
  xxh64_pkg::u64_t  digest_q, digest_d;

  logic             need_mul;
  logic             mul_start, mul_done, mul_fire;
  xxh64_pkg::u64_t  op_a, op_b, mul_res;
  xxh64_pkg::u64_t  lane_in, tail_op, sel_lane;
  logic [3:0]       n_eff;
  logic             end_eff, drop, accept;

  // APB seed register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? seed_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= xxh64_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
      seed_q <= pwdata;
    end
  end

  // Normalize the incoming word
  assign n_eff   = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
  assign end_eff = last_i || (n_eff != 4'd0 && n_eff < 4'd8);
  assign drop    = (n_eff == 4'd0) && !end_eff;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept  = in_valid_i && in_ready_o;

  assign sel_lane = lane_q[i_q];
  assign lane_in  = (i_q == 2'd3) ? w_q : pend_q[i_q];
  assign tail_op  = (i_q < pcnt_q) ? pend_q[i_q] : w_q;

  // Operand select for the shared multiplier
  always_comb begin
    op_a     = h_q;
    op_b     = xxh64_pkg::PRIME1;
    need_mul = 1'b0;
    unique case (state_q)
      S_LR1: begin
        op_a = lane_in;  op_b = xxh64_pkg::PRIME2; need_mul = 1'b1;
      end
      S_LR2: begin
        op_a = xxh64_pkg::rotl64(sel_lane + t_q, 31); need_mul = 1'b1;
      end
      S_ML1: begin
        op_a = sel_lane; op_b = xxh64_pkg::PRIME2; need_mul = 1'b1;
      end
      S_ML2: begin
        op_a = xxh64_pkg::rotl64(t_q, 31); need_mul = 1'b1;
      end
      S_ML3: begin
        op_a = h_q; need_mul = 1'b1;
      end
      S_T1: begin
        op_a = tail_op; op_b = xxh64_pkg::PRIME2;
        need_mul = (i_q < pcnt_q) || (n_q == 4'd8);
      end
      S_T2: begin
        op_a = xxh64_pkg::rotl64(t_q, 31); need_mul = 1'b1;
      end
      S_T3: begin
        op_a = xxh64_pkg::rotl64(h_q, 27); need_mul = 1'b1;
      end
      S_P4: begin
        op_a = {32'd0, w_q[31:0]}; need_mul = (n_q >= 4'd4);
      end
      S_P4B: begin
        op_a = xxh64_pkg::rotl64(h_q, 23); op_b = xxh64_pkg::PRIME2; need_mul = 1'b1;
      end
      S_B1: begin
        op_a = {56'd0, w_q[8*b_q +: 8]}; op_b = xxh64_pkg::PRIME5;
        need_mul = ({1'b0, b_q} < n_q);
      end
      S_B2: begin
        op_a = xxh64_pkg::rotl64(h_q, 11); need_mul = 1'b1;
      end
      S_AV1: begin
        op_a = h_q ^ (h_q >> 33); op_b = xxh64_pkg::PRIME2; need_mul = 1'b1;
      end
      S_AV2: begin
        op_a = h_q ^ (h_q >> 29); op_b = xxh64_pkg::PRIME3; need_mul = 1'b1;
      end
      default: need_mul = 1'b0;
    endcase
  end

  assign mul_start = need_mul && !issued_q;
  assign mul_fire  = issued_q && mul_done;

  xxh64_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (op_a),
    .b_i      (op_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    pend_we     = 1'b0;
    pcnt_d      = pcnt_q;
    total_d     = total_q;
    stripe_d    = stripe_q;
    w_d         = w_q;
    n_d         = n_q;
    end_d       = end_q;
    h_d         = h_q;
    t_d         = t_q;
    i_d         = i_q;
    b_d         = b_q;
    issued_d    = issued_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (mul_start) issued_d = 1'b1;
    if (mul_fire)  issued_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !drop) begin
          total_d = total_q + LENGTH_BITS'(n_eff);
          w_d     = word_i;
          n_d     = n_eff;
          end_d   = end_eff;
          if (n_eff == 4'd8 && pcnt_q == 2'd3) begin
            if (!stripe_q) begin
              lane_d[0] = seed_q + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
              lane_d[1] = seed_q + xxh64_pkg::PRIME2;
              lane_d[2] = seed_q;
              lane_d[3] = seed_q - xxh64_pkg::PRIME1;
            end
            i_d     = 2'd0;
            state_d = S_LR1;
          end else if (n_eff == 4'd8 && !end_eff) begin
            pend_we = 1'b1;
            pcnt_d  = pcnt_q + 2'd1;
          end else begin
            state_d = S_FINIT;
          end
        end
      end
      S_LR1: if (mul_fire) begin
        t_d     = mul_res;
        state_d = S_LR2;
      end
      S_LR2: if (mul_fire) begin
        lane_d[i_q] = mul_res;
        if (i_q == 2'd3) begin
          pcnt_d   = 2'd0;
          stripe_d = 1'b1;
          n_d      = 4'd0;
          state_d  = end_q ? S_FINIT : S_IDLE;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_LR1;
        end
      end
      S_FINIT: begin
        i_d = 2'd0;
        if (stripe_q) begin
          h_d = xxh64_pkg::rotl64(lane_q[0], 1) + xxh64_pkg::rotl64(lane_q[1], 7) +
                xxh64_pkg::rotl64(lane_q[2], 12) + xxh64_pkg::rotl64(lane_q[3], 18);
          state_d = S_ML1;
        end else begin
          h_d     = seed_q + xxh64_pkg::PRIME5;
          state_d = S_LEN;
        end
      end
      S_ML1: if (mul_fire) begin
        t_d     = mul_res;
        state_d = S_ML2;
      end
      S_ML2: if (mul_fire) begin
        h_d     = h_q ^ mul_res;
        state_d = S_ML3;
      end
      S_ML3: if (mul_fire) begin
        h_d = mul_res + xxh64_pkg::PRIME4;
        if (i_q == 2'd3) begin
          state_d = S_LEN;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_ML1;
        end
      end
      S_LEN: begin
        h_d     = h_q + 64'(total_q);
        i_d     = 2'd0;
        state_d = S_T1;
      end
      S_T1: begin
        if (!need_mul) begin
          state_d = S_P4;
        end else if (mul_fire) begin
          t_d     = mul_res;
          state_d = S_T2;
        end
      end
      S_T2: if (mul_fire) begin
        h_d     = h_q ^ mul_res;
        state_d = S_T3;
      end
      S_T3: if (mul_fire) begin
        h_d = mul_res + xxh64_pkg::PRIME4;
        if (i_q == pcnt_q) begin
          state_d = S_AV1;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_T1;
        end
      end
      S_P4: begin
        if (!need_mul) begin
          b_d     = 3'd0;
          state_d = S_B1;
        end else if (mul_fire) begin
          h_d     = h_q ^ mul_res;
          state_d = S_P4B;
        end
      end
      S_P4B: if (mul_fire) begin
        h_d     = mul_res + xxh64_pkg::PRIME3;
        b_d     = 3'd4;
        state_d = S_B1;
      end
      S_B1: begin
        if (!need_mul) begin
          state_d = S_AV1;
        end else if (mul_fire) begin
          h_d     = h_q ^ mul_res;
          state_d = S_B2;
        end
      end
      S_B2: if (mul_fire) begin
        h_d     = mul_res;
        b_d     = b_q + 3'd1;
        state_d = S_B1;
      end
      S_AV1: if (mul_fire) begin
        h_d     = mul_res;
        state_d = S_AV2;
      end
      S_AV2: if (mul_fire) begin
        h_d     = mul_res;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          digest_d    = h_q ^ (h_q >> 32);
          out_valid_d = 1'b1;
          pcnt_d      = 2'd0;
          total_d     = '0;
          stripe_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pcnt_q      <= 2'd0;
      total_q     <= '0;
      stripe_q    <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcnt_q      <= pcnt_d;
      total_q     <= total_d;
      stripe_q    <= stripe_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lane_q   <= lane_d;
    w_q      <= w_d;
    n_q      <= n_d;
    end_q    <= end_d;
    h_q      <= h_d;
    t_q      <= t_d;
    i_q      <= i_d;
    b_q      <= b_d;
    digest_q <= digest_d;
    if (pend_we) begin
      pend_q[pcnt_q] <= word_i;
    end
  end

endmodule
